### hw/rtl/box_mean_filter_top_defines.svh
// Assertion macros for the box mean filter top level.
`ifndef BOX_MEAN_FILTER_TOP_DEFINES_SVH
`define BOX_MEAN_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bmf_pkg.sv
// Types, register indexes and divider constants for the box mean filter.
package bmf_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int HALF_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF  = 2'd2;

    // Window counters count 0 .. 2*half, half at most 3
    localparam int CNT_W = 3;

    // Window sum: at most 49 * 255
    localparam int SUM_W       = 14;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_end;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TAIL,
        S_MUL,
        S_OUT
    } state_t;

    // ceil(2^20 / (2*half+1)^2); exact for every window sum that can occur
    function automatic logic [RECIP_W-1:0] recip(input logic [HALF_W-1:0] half);
        logic [RECIP_W-1:0] r;
        unique case (half)
            2'd0:    r = 21'd1048576;
            2'd1:    r = 21'd116509;
            2'd2:    r = 21'd41944;
            default: r = 21'd21400;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/bmf_ram.sv
// Generic simple dual-port RAM with registered read.
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6151
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/box_mean_filter_top.sv
// Streaming zero-padded box mean filter, top level.
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+----------------------
//  input   | s_valid s_ready s_data         | s_valid & s_ready
//  result  | m_valid m_ready m_data         | m_valid & m_ready
//  config  | cfg_valid cfg_ready cfg_index  | cfg_valid & cfg_ready
//          | cfg_data                       |
//
// An item that releases no result leaves the filter ready for the next item.
// An item that releases one reads the pixel history RAM once per window tap
// through its single read port, then multiplies and loads the output register.
// Synchronous active-low reset clears control state; the history RAM is not
// cleared, and taps that lie outside the image are read but not summed.
// A full output register stalls only the final step of the next item.
module box_mean_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_HALF   = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bmf_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bmf_pkg::out_item_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "box_mean_filter_top_defines.svh"

    localparam int HIST_DEPTH = 2 * MAX_HALF * MAX_WIDTH + 2 * MAX_HALF + 1;
    localparam int AD_W  = $clog2(HIST_DEPTH);
    localparam int EW_W  = $clog2(MAX_WIDTH + 1);
    localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + MAX_HALF + 2);
    localparam int SR_W  = ROW_W + 1;
    localparam int SC_W  = $clog2(MAX_WIDTH + MAX_HALF + 1) + 1;
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_HALF * MAX_WIDTH + MAX_HALF + 1);
    localparam int LAG_W = EW_W + 3;
    localparam int CNT_W = bmf_pkg::CNT_W;
    localparam int SUM_W = bmf_pkg::SUM_W;

    // Control and payload registers
    bmf_pkg::state_t               state_reg, state_next;
    logic [bmf_pkg::WIDTH_W-1:0]   width_cfg_reg, width_cfg_next;
    logic [bmf_pkg::HEIGHT_W-1:0]  height_cfg_reg, height_cfg_next;
    logic [bmf_pkg::HALF_W-1:0]    half_cfg_reg, half_cfg_next;
    logic [ROW_W-1:0]              in_row_reg, in_row_next;
    logic [COL_W-1:0]              in_col_reg, in_col_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [AD_W-1:0]               wr_addr_reg, wr_addr_next;
    logic [ROW_W-1:0]              out_row_reg, out_row_next;
    logic [COL_W-1:0]              out_col_reg, out_col_next;
    logic                          issue_d_reg, issue_d_next;
    logic                          inimg_d_reg, inimg_d_next;
    logic                          m_valid_reg, m_valid_next;
    logic [AD_W-1:0]               ra_reg, ra_next;
    logic [AD_W-1:0]               a_reg, a_next;
    logic [SR_W-1:0]               r_reg, r_next;
    logic [SC_W-1:0]               c_reg, c_next;
    logic [CNT_W-1:0]              kcnt_reg, kcnt_next;
    logic [CNT_W-1:0]              lcnt_reg, lcnt_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [bmf_pkg::PROD_W-1:0]    prod_reg, prod_next;
    bmf_pkg::out_item_t            m_data_reg, m_data_next;

    // Effective geometry
    logic [EW_W-1:0]               w_eff;
    logic [EH_W-1:0]               h_eff;
    logic [bmf_pkg::HALF_W-1:0]    half_eff;
    logic [CNT_W-1:0]              side_max;
    logic [LAG_W-1:0]              lag_val;
    logic [AD_W:0]                 start_sum;
    logic [AD_W-1:0]               start_addr;
    logic [AD_W:0]                 ra_step;
    logic [AD_W-1:0]               ra_wrap;

    // Handshake and datapath helpers
    logic                          accept;
    logic                          in_frame;
    logic                          skip;
    logic                          in_lag;
    logic                          last_out;
    logic                          inimg;
    logic                          ram_we;
    logic                          ram_re;
    logic [7:0]                    wr_val;
    logic [7:0]                    rdata;
    logic [SR_W-1:0]               r_start;
    logic [SC_W-1:0]               c_start;

    // Clamp configuration to supported ranges
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = EW_W'(1);
        end else if (32'(width_cfg_reg) > 32'(MAX_WIDTH)) begin
            w_eff = EW_W'(MAX_WIDTH);
        end else begin
            w_eff = EW_W'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = EH_W'(1);
        end else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = EH_W'(MAX_HEIGHT);
        end else begin
            h_eff = EH_W'(height_cfg_reg);
        end
        if (32'(half_cfg_reg) > 32'(MAX_HALF)) begin
            half_eff = bmf_pkg::HALF_W'(MAX_HALF);
        end else begin
            half_eff = half_cfg_reg;
        end
    end

    assign side_max = CNT_W'({half_eff, 1'b0});
    assign lag_val  = LAG_W'(half_eff) * LAG_W'(w_eff) + LAG_W'(half_eff);

    // Oldest tap of the window: current write address minus 2*lag, modulo depth
    assign start_sum  = (AD_W + 1)'(wr_addr_reg) + (AD_W + 1)'(HIST_DEPTH)
                      - (AD_W + 1)'({lag_val, 1'b0});
    assign start_addr = (start_sum >= (AD_W + 1)'(HIST_DEPTH))
                      ? AD_W'(start_sum - (AD_W + 1)'(HIST_DEPTH)) : AD_W'(start_sum);

    // Next row of the window is one image row later in the history
    assign ra_step = (AD_W + 1)'(ra_reg) + (AD_W + 1)'(w_eff);
    assign ra_wrap = (ra_step >= (AD_W + 1)'(HIST_DEPTH))
                   ? AD_W'(ra_step - (AD_W + 1)'(HIST_DEPTH)) : AD_W'(ra_step);

    assign r_start = SR_W'(out_row_reg) - SR_W'(half_eff);
    assign c_start = SC_W'(out_col_reg) - SC_W'(half_eff);

    // Tap lies inside the image
    assign inimg = !r_reg[SR_W-1] && (r_reg[SR_W-2:0] < (SR_W - 1)'(h_eff))
                && !c_reg[SC_W-1] && (c_reg[SC_W-2:0] < (SC_W - 1)'(w_eff));

    assign s_ready   = (state_reg == bmf_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign in_frame  = 32'(in_row_reg) < 32'(h_eff);
    assign skip      = in_frame && s_data.kind;
    assign in_lag    = 32'(pos_reg) < 32'(lag_val);
    assign wr_val    = in_frame ? s_data.pixel_in : 8'd0;
    assign last_out  = (32'(out_row_reg) + 32'd1 >= 32'(h_eff))
                    && (32'(out_col_reg) + 32'd1 >= 32'(w_eff));
    assign ram_we    = accept && !skip;
    assign ram_re    = (state_reg == bmf_pkg::S_READ);

    // Pixel history
    bmf_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (wr_val),
        .re    (ram_re),
        .raddr (a_reg),
        .rdata (rdata)
    );

    // Next state, counters and datapath
    always_comb begin
        state_next      = state_reg;
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        half_cfg_next   = half_cfg_reg;
        in_row_next     = in_row_reg;
        in_col_next     = in_col_reg;
        pos_next        = pos_reg;
        wr_addr_next    = wr_addr_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        ra_next         = ra_reg;
        a_next          = a_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        kcnt_next       = kcnt_reg;
        lcnt_next       = lcnt_reg;
        prod_next       = prod_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        issue_d_next    = ram_re;
        inimg_d_next    = inimg;

        // Accumulate taps as read data returns
        if (accept) begin
            sum_next = '0;
        end else if (issue_d_reg && inimg_d_reg) begin
            sum_next = sum_reg + SUM_W'(rdata);
        end else begin
            sum_next = sum_reg;
        end

        unique case (state_reg)
            bmf_pkg::S_IDLE: begin
                if (accept && !skip) begin
                    pos_next = pos_reg + POS_W'(1);
                    wr_addr_next = (32'(wr_addr_reg) + 32'd1 >= 32'(HIST_DEPTH))
                                 ? '0 : wr_addr_reg + AD_W'(1);
                    if (32'(in_col_reg) + 32'd1 >= 32'(w_eff)) begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + ROW_W'(1);
                    end else begin
                        in_col_next = in_col_reg + COL_W'(1);
                    end
                    if (!in_lag) begin
                        state_next = bmf_pkg::S_READ;
                        ra_next    = start_addr;
                        a_next     = start_addr;
                        r_next     = r_start;
                        c_next     = c_start;
                        kcnt_next  = '0;
                        lcnt_next  = '0;
                    end
                end
            end
            bmf_pkg::S_READ: begin
                if (lcnt_reg == side_max) begin
                    lcnt_next = '0;
                    if (kcnt_reg == side_max) begin
                        state_next = bmf_pkg::S_TAIL;
                    end else begin
                        kcnt_next = kcnt_reg + CNT_W'(1);
                        r_next    = r_reg + SR_W'(1);
                        c_next    = c_start;
                        ra_next   = ra_wrap;
                        a_next    = ra_wrap;
                    end
                end else begin
                    lcnt_next = lcnt_reg + CNT_W'(1);
                    c_next    = c_reg + SC_W'(1);
                    a_next    = (32'(a_reg) + 32'd1 >= 32'(HIST_DEPTH))
                              ? '0 : a_reg + AD_W'(1);
                end
            end
            bmf_pkg::S_TAIL: begin
                state_next = bmf_pkg::S_MUL;
            end
            bmf_pkg::S_MUL: begin
                prod_next  = bmf_pkg::PROD_W'(sum_reg)
                           * bmf_pkg::PROD_W'(bmf_pkg::recip(half_eff));
                state_next = bmf_pkg::S_OUT;
            end
            bmf_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.pixel_out = prod_reg[bmf_pkg::RECIP_SHIFT +: 8];
                    m_data_next.frame_end = last_out;
                    state_next            = bmf_pkg::S_IDLE;
                    if (last_out) begin
                        in_row_next  = '0;
                        in_col_next  = '0;
                        pos_next     = '0;
                        wr_addr_next = '0;
                        out_row_next = '0;
                        out_col_next = '0;
                    end else if (32'(out_col_reg) + 32'd1 >= 32'(w_eff)) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
            default: begin
                state_next = bmf_pkg::S_IDLE;
            end
        endcase

        // Register write restarts the frame
        if (cfg_valid) begin
            unique case (cfg_index)
                bmf_pkg::REG_IMAGE_WIDTH:  width_cfg_next  = cfg_data[bmf_pkg::WIDTH_W-1:0];
                bmf_pkg::REG_IMAGE_HEIGHT: height_cfg_next = cfg_data[bmf_pkg::HEIGHT_W-1:0];
                bmf_pkg::REG_WINDOW_HALF:  half_cfg_next   = cfg_data[bmf_pkg::HALF_W-1:0];
                default: ;
            endcase
            if (cfg_index == bmf_pkg::REG_IMAGE_WIDTH || cfg_index == bmf_pkg::REG_IMAGE_HEIGHT
                || cfg_index == bmf_pkg::REG_WINDOW_HALF) begin
                in_row_next  = '0;
                in_col_next  = '0;
                pos_next     = '0;
                wr_addr_next = '0;
                out_row_next = '0;
                out_col_next = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bmf_pkg::S_IDLE;
            width_cfg_reg  <= bmf_pkg::WIDTH_W'(100);
            height_cfg_reg <= bmf_pkg::HEIGHT_W'(100);
            half_cfg_reg   <= bmf_pkg::HALF_W'(1);
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            pos_reg        <= '0;
            wr_addr_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            issue_d_reg    <= 1'b0;
            inimg_d_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            half_cfg_reg   <= half_cfg_next;
            in_row_reg     <= in_row_next;
            in_col_reg     <= in_col_next;
            pos_reg        <= pos_next;
            wr_addr_reg    <= wr_addr_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            issue_d_reg    <= issue_d_next;
            inimg_d_reg    <= inimg_d_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Window walk and arithmetic
    always_ff @(posedge aclk) begin
        ra_reg     <= ra_next;
        a_reg      <= a_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        kcnt_reg   <= kcnt_next;
        lcnt_reg   <= lcnt_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `BMF_ASSERT_NOW(a_rd_addr_range, ram_re, 32'(a_reg) < 32'(HIST_DEPTH), "history read out of range")
    `BMF_ASSERT_NOW(a_mul_drained, state_reg == bmf_pkg::S_MUL, !issue_d_reg, "multiply before last tap")
    `BMF_ASSERT_NEXT(a_frame_restart, state_reg == bmf_pkg::S_OUT && (!m_valid_reg || m_ready) && last_out && !cfg_valid, pos_reg == '0 && out_row_reg == '0, "counters not cleared at frame end")

endmodule
